// ===== design/djrs_pkg.sv =====
package djrs_pkg;

	localparam int JOBS_DEF     = 16;
	localparam int SYNCS_DEF    = 8;
	localparam int TASKS_DEF    = 16;
	localparam int KEY_BITS_DEF = 16;

	typedef enum logic [2:0] {
		CMD_LOAD   = 3'd0,
		CMD_START  = 3'd1,
		CMD_NEXT   = 3'd2,
		CMD_FINISH = 3'd3,
		CMD_SYNC   = 3'd4,
		CMD_PEND   = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  job_index;
		logic [15:0] dep_row;
		logic [7:0]  sync_row;
		logic [7:0]  deadline_bits;
		logic [3:0]  task_id;
		logic [15:0] latest_finish;
		logic [2:0]  sync_index;
	} in_item_t;

	typedef struct packed {
		logic       task_valid;
		logic [3:0] task_out;
		logic       period_miss;
		logic       sync_miss;
	} out_item_t;

endpackage

// ===== design/djrs_walk.sv =====
module djrs_walk #(
	parameter int JOBS     = 16,
	parameter int SYNCS    = 8,
	parameter int KEY_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  djrs_pkg::in_item_t   item,
	output logic                 done,
	output djrs_pkg::out_item_t  result
);
	import djrs_pkg::*;

	localparam int JW = $clog2(JOBS);
	localparam int SW = (SYNCS > 1) ? $clog2(SYNCS) : 1;

	typedef enum logic [2:0] {S_IDLE, S_COPY, S_SCAN, S_CLEAR, S_READY, S_DONE} state_t;

	logic [JOBS-1:0]     dep_tpl [JOBS];
	logic [SYNCS-1:0]    sync_tpl [JOBS];
	logic [SYNCS-1:0]    dl_tpl [JOBS];
	logic [3:0]          task_tbl [JOBS];
	logic [KEY_BITS-1:0] key_tbl [JOBS];
	logic [JOBS-1:0]     dep_q [JOBS];
	logic [SYNCS-1:0]    sync_q [JOBS];
	logic [SYNCS-1:0]    dl_q [JOBS];
	logic [JOBS-1:0]     queued_q, started_q, finished_q, marked_q;

	state_t              state_q;
	logic [JW-1:0]       k_q;
	logic                found_q;
	logic [JW-1:0]       best_q;
	logic [KEY_BITS-1:0] best_key_q;
	in_item_t            item_q;
	out_item_t           res_q;

	logic                last;
	logic                sync_ok;
	logic [SW-1:0]       sidx;
	logic                task_hit;
	logic                result_fix;

	assign last     = (k_q == JW'(JOBS - 1));
	assign sync_ok  = ({29'd0, item_q.sync_index} < 32'(SYNCS));
	assign sidx     = SW'(item_q.sync_index);
	assign task_hit = (task_tbl[k_q] == item_q.task_id) && started_q[k_q] && !finished_q[k_q];

	always_ff @(posedge clk) begin
		if (go && item.cmd == CMD_LOAD && {28'd0, item.job_index} < 32'(JOBS)) begin
			dep_tpl[JW'(item.job_index)]  <= JOBS'(item.dep_row);
			sync_tpl[JW'(item.job_index)] <= SYNCS'(item.sync_row);
			dl_tpl[JW'(item.job_index)]   <= SYNCS'(item.deadline_bits);
			task_tbl[JW'(item.job_index)] <= item.task_id;
			key_tbl[JW'(item.job_index)]  <= KEY_BITS'(item.latest_finish);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			k_q        <= '0;
			queued_q   <= '0;
			started_q  <= '0;
			finished_q <= '0;
			marked_q   <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			best_key_q <= '0;
			item_q     <= '0;
			res_q      <= '0;
			for (int i = 0; i < JOBS; i++) begin
				dep_q[i]  <= '0;
				sync_q[i] <= '0;
				dl_q[i]   <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (go) begin
						item_q  <= item;
						res_q   <= out_item_t'{1'b0, 4'd0,
							(item.cmd == CMD_PEND) && (finished_q != '1), 1'b0};
						k_q     <= '0;
						found_q <= 1'b0;
						case (item.cmd)
							CMD_START:  state_q <= S_COPY;
							CMD_PEND:   state_q <= S_COPY;
							CMD_NEXT:   state_q <= S_SCAN;
							CMD_FINISH: state_q <= S_SCAN;
							CMD_SYNC:   state_q <= S_SCAN;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_COPY: begin
					dep_q[k_q]  <= dep_tpl[k_q];
					sync_q[k_q] <= sync_tpl[k_q];
					dl_q[k_q]   <= dl_tpl[k_q];
					k_q <= last ? '0 : k_q + 1'b1;
					if (last) begin
						queued_q   <= '0;
						started_q  <= '0;
						finished_q <= '0;
						marked_q   <= '0;
						state_q    <= S_READY;
					end
				end
				S_SCAN: begin
					if (item_q.cmd == CMD_FINISH && task_hit)
						k_q <= '0;
					else
						k_q <= last ? '0 : k_q + 1'b1;
					if (item_q.cmd == CMD_NEXT) begin
						if (queued_q[k_q] && !started_q[k_q] &&
							(!found_q || key_tbl[k_q] < best_key_q)) begin
							found_q    <= 1'b1;
							best_q     <= k_q;
							best_key_q <= key_tbl[k_q];
						end
						if (last) state_q <= S_DONE;
					end else if (item_q.cmd == CMD_SYNC) begin
						if (sync_ok) begin
							sync_q[k_q][sidx] <= 1'b0;
							if (dl_q[k_q][sidx]) res_q.sync_miss <= 1'b1;
						end
						if (last) begin
							marked_q <= queued_q | started_q | finished_q;
							state_q  <= S_READY;
						end
					end else begin
						if (task_hit) begin
							found_q <= 1'b1;
							best_q  <= k_q;
							finished_q[k_q] <= 1'b1;
							dl_q[k_q] <= '0;
							state_q <= S_CLEAR;
						end else if (last) begin
							marked_q <= queued_q | started_q | finished_q;
							state_q  <= S_READY;
						end
					end
				end
				S_CLEAR: begin
					dep_q[k_q][best_q] <= 1'b0;
					k_q <= last ? '0 : k_q + 1'b1;
					if (last) begin
						marked_q <= queued_q | started_q | finished_q;
						state_q  <= S_READY;
					end
				end
				S_READY: begin
					if (dep_q[k_q] == '0 && sync_q[k_q] == '0 && !marked_q[k_q])
						queued_q[k_q] <= 1'b1;
					k_q <= last ? '0 : k_q + 1'b1;
					if (last) state_q <= S_DONE;
				end
				S_DONE: begin
					if (item_q.cmd == CMD_NEXT && found_q) begin
						started_q[best_q] <= 1'b1;
						res_q <= out_item_t'{1'b1, task_tbl[best_q], 1'b0, 1'b0};
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = (state_q == S_IDLE);
	assign result = res_q;

	always_comb begin
		if (state_q == S_DONE && item_q.cmd == CMD_NEXT && found_q)
			result_fix = 1'b1;
		else
			result_fix = 1'b0;
	end

	ap_fin_started: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q & ~started_q) == '0) else $error("finished job never started");
	ap_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> state_q == S_IDLE) else $error("item taken while busy");
	ap_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		result_fix |=> res_q.task_valid) else $error("dispatch lost");

endmodule

// ===== design/dag_job_ready_scheduler_top.sv =====
// Steps to a result: load and unknown codes go straight to done; next task scans the rows;
// start and period end copy, then mark ready; sync scans, then marks ready; task finished
// scans, clears, marks ready: one job row per cycle through the shared walk sequencer.
// One item at a time: the next item can be taken in the same cycle the result appears at
// the earliest, and not while that result is stalled.
// Asynchronous active-low reset clears working rows and marks; tables are unset.
module dag_job_ready_scheduler_top #(
	parameter int JOBS     = djrs_pkg::JOBS_DEF,
	parameter int SYNCS    = djrs_pkg::SYNCS_DEF,
	parameter int KEY_BITS = djrs_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  djrs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output djrs_pkg::out_item_t out_data
);
	import djrs_pkg::*;

	logic      go, done, done_q, busy_q;
	out_item_t res;

	assign in_stall = busy_q || !done || (out_valid && out_stall);
	assign go       = in_valid && !in_stall;

	djrs_walk #(.JOBS(JOBS), .SYNCS(SYNCS), .KEY_BITS(KEY_BITS)) u_walk (
		.clk(clk), .arst_n(arst_n), .go(go), .item(in_data), .done(done), .result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			done_q <= done;
			if (go) busy_q <= 1'b1;
			else if (busy_q && done && !done_q) busy_q <= 1'b0;
			if (busy_q && done && !done_q) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && done && !done_q) out_data <= res;
	end

endmodule
